FILE: design/per_client_flood_token_bucket_macros.svh
// Assertion macros shared by the flood limiter RTL.
`ifndef PER_CLIENT_FLOOD_TOKEN_BUCKET_MACROS_SVH
`define PER_CLIENT_FLOOD_TOKEN_BUCKET_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define FCB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("flood limiter check failed");

// Next-cycle implication, disabled while reset is held.
`define FCB_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("flood limiter check failed");

`endif

FILE: design/fcb_pkg.sv
// Shared types, codes and constants of the per-client flood limiter.
`timescale 1ns / 1ps
`default_nettype none
package fcb_pkg;

    localparam int NUM_CLIENTS_DEF = 1024;

    localparam int ID_W      = 10;
    localparam int CLASS_W   = 2;
    localparam int LINES_W   = 12;
    localparam int AGE_W     = 16;
    localparam int COST_W    = 8;
    localparam int CTR_W     = 19;
    localparam int OUT_CTR_W = 18;
    localparam int QUOT_W    = 10;   // quotient never exceeds 4 * 255
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TDATA_W   = 48;
    localparam int TUSER_W   = 2;

    localparam logic [7:0]  BURST_MAX_RST  = 8'd10;
    localparam logic [7:0]  BURST_RATE_RST = 8'd5;
    localparam logic [7:0]  COST_RST       = 8'd1;
    localparam logic [7:0]  DRAIN_RST      = 8'd1;
    localparam logic        BONUS_RST      = 1'b0;
    localparam logic [15:0] DELAY_RST      = 16'd0;
    localparam logic [11:0] MAXQ_RST       = 12'd20;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_READ,
        CMD_END_GRACE,
        CMD_NEW_CLIENT
    } fcb_cmd_t;

    typedef enum logic [1:0] {
        CLS_UNKNOWN,
        CLS_REGISTERED,
        CLS_SERVER,
        CLS_EXEMPT
    } fcb_class_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BURST_MAX,
        CFG_BURST_RATE,
        CFG_MESSAGE_COST,
        CFG_DRAIN_PER_TICK,
        CFG_OPER_BONUS,
        CFG_GRACE_DELAY,
        CFG_MAX_QUEUED
    } fcb_cfg_t;

    typedef struct packed {
        logic             grace_done;
        logic [CTR_W-1:0] flood_counter;
    } fcb_entry_t;

    typedef struct packed {
        logic              start;
        logic [CTR_W-1:0]  dividend;
        logic [COST_W-1:0] divisor;
    } fcb_div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } fcb_div_rsp_t;

endpackage
`default_nettype wire

FILE: design/fcb_mem.sv
// Client state table: registered-read memory with a clearing sweep after reset.
`timescale 1ns / 1ps
`default_nettype none
module fcb_mem import fcb_pkg::*; #(
    parameter int DEPTH = NUM_CLIENTS_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output fcb_entry_t    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  fcb_entry_t    wr_data,
    output logic          clr_busy
);

    fcb_entry_t    mem [DEPTH];
    fcb_entry_t    rd_data_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule
`default_nettype wire

FILE: design/fcb_div.sv
// Restoring divider: one quotient bit per cycle, quotient known to fit QUOT_W bits.
`timescale 1ns / 1ps
`default_nettype none
module fcb_div import fcb_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  fcb_div_req_t req,
    output fcb_div_rsp_t rsp
);

    localparam int STEP_W = $clog2(QUOT_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CTR_W-1:0]  rem_reg;
    logic [COST_W-1:0] den_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [CTR_W-1:0]  shifted;
    logic              ge;

    assign shifted = {{(CTR_W - COST_W){1'b0}}, den_reg} << step_reg;
    assign ge      = rem_reg >= shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            if (req.start) begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                step_reg <= STEP_W'(QUOT_W - 1);
            end else if (busy_reg) begin
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    done_reg <= 1'b0;
                    step_reg <= step_reg - 1'b1;
                end
            end else begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= req.dividend;
            den_reg  <= req.divisor;
            quot_reg <= '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - shifted;
            end
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule
`default_nettype wire

FILE: design/per_client_flood_token_bucket.sv
// Top level of the per-client flood limiter: config registers, sequencer, result register.
//
// Usage:
//   s_ channel carries one item per client event: s_tuser holds the command
//   (tick, read, end grace, new client), s_tdata the client fields. The
//   m_ channel returns exactly one result item for every input item, in order.
//   Config registers are written through cfg_we / cfg_addr / cfg_wdata while
//   the block is idle; writes take effect at the next clock edge.
// Sequencing:
//   One item at a time. End-grace, new-client and out-of-range items go from
//   the read and drain steps straight to the result; unknown, server, exempt
//   and non-admitted registered items take an admission step first, and
//   admitted registered items also pass the ten-step divider, a multiply and
//   an add. The next item is taken in the cycle after the result is loaded.
// Reset:
//   aresetn is synchronous, active low. After release the client table is
//   swept to zero, one entry per cycle, with s_tready low.
// Stall:
//   The result sits in an output register; the block takes the next item while
//   it waits, and holds a second result until the first one is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "per_client_flood_token_bucket_macros.svh"
module per_client_flood_token_bucket import fcb_pkg::*; #(
    parameter int NUM_CLIENTS = NUM_CLIENTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [9:0] client_id, [11:10] client_class, [12] is_oper,
    // [24:13] queued_lines, [40:25] connect_age, [47:41] zero
    input  logic [TDATA_W-1:0]    s_tdata,
    // [1:0] cmd
    input  logic [TUSER_W-1:0]    s_tuser,
    // result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [9:0] client_out, [21:10] lines_admitted, [22] excess_flood,
    // [40:23] counter_after, [47:41] zero
    output logic [TDATA_W-1:0]    m_tdata
);

    localparam int AW = $clog2(NUM_CLIENTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_ADMIT,
        S_DIV,
        S_MUL,
        S_ADD,
        S_FINISH
    } state_t;

    // ---------------- configuration registers ----------------
    logic [7:0]         burst_max_reg;
    logic [7:0]         burst_rate_reg;
    logic [COST_W-1:0]  cost_reg;
    logic [7:0]         drain_reg;
    logic               bonus_en_reg;
    logic [AGE_W-1:0]   delay_reg;
    logic [LINES_W-1:0] maxq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            burst_max_reg  <= BURST_MAX_RST;
            burst_rate_reg <= BURST_RATE_RST;
            cost_reg       <= COST_RST;
            drain_reg      <= DRAIN_RST;
            bonus_en_reg   <= BONUS_RST;
            delay_reg      <= DELAY_RST;
            maxq_reg       <= MAXQ_RST;
        end else if (cfg_we) begin
            case (fcb_cfg_t'(cfg_addr))
                CFG_BURST_MAX:      burst_max_reg  <= cfg_wdata[7:0];
                CFG_BURST_RATE:     burst_rate_reg <= cfg_wdata[7:0];
                CFG_MESSAGE_COST:   cost_reg       <= cfg_wdata[COST_W-1:0];
                CFG_DRAIN_PER_TICK: drain_reg      <= cfg_wdata[7:0];
                CFG_OPER_BONUS:     bonus_en_reg   <= cfg_wdata[0];
                CFG_GRACE_DELAY:    delay_reg      <= cfg_wdata[AGE_W-1:0];
                CFG_MAX_QUEUED:     maxq_reg       <= cfg_wdata[LINES_W-1:0];
                default: ;          // unused index: write dropped
            endcase
        end
    end

    // ---------------- state ----------------
    state_t             state_reg;
    logic               m_tvalid_reg;
    logic [TDATA_W-1:0] m_tdata_reg;

    // item fields, latched at accept
    fcb_cmd_t           cmd_reg;
    fcb_class_t         cls_reg;
    logic [ID_W-1:0]    id_reg;
    logic               oper_reg;
    logic [LINES_W-1:0] queued_reg;
    logic [AGE_W-1:0]   age_reg;
    logic               in_range_reg;

    // working values
    logic [CTR_W-1:0]   ctr_reg;
    logic               grace_reg;
    logic [CTR_W-1:0]   limit_reg;
    logic [CTR_W-1:0]   ceil_reg;
    logic [LINES_W-1:0] adm_reg;
    logic [CTR_W-1:0]   prod_reg;

    // memory and divider hookup
    fcb_entry_t   mem_rd_data;
    fcb_entry_t   mem_wr_data;
    logic         mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0]  id_ext;
    logic         clr_busy;
    fcb_div_req_t div_req;
    fcb_div_rsp_t div_rsp;

    logic s_accept;
    logic out_free;

    assign s_tready = (state_reg == S_IDLE) && !clr_busy;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign id_ext   = 32'(id_reg);
    assign mem_addr = id_ext[AW-1:0];

    // ---------------- datapath ----------------
    logic               bonus_c;
    logic [CTR_W-1:0]   drain_ctr;
    logic [15:0]        mul_c;
    logic [CTR_W-1:0]   limit_c;
    logic [CTR_W-1:0]   bm_ext;
    logic               unk_below;
    logic [CTR_W-1:0]   unk_gap;
    logic [LINES_W-1:0] unk_gap_l;
    logic [LINES_W-1:0] adm_unk;
    logic [CTR_W:0]     unk_sum;
    logic [CTR_W-1:0]   ctr_unk;
    logic [CTR_W-1:0]   ceil_c;
    logic               reg_go;
    logic [CTR_W-1:0]   ctr_clamp;
    logic [LINES_W-1:0] quot_l;
    logic [LINES_W-1:0] adm_div;
    logic [CTR_W:0]     add_sum;
    logic [CTR_W-1:0]   ctr_add;
    logic [LINES_W-1:0] left_lines;
    logic               excess_c;

    assign bonus_c = bonus_en_reg && oper_reg;

    always_comb begin
        // tick drain, applied on the counter just read
        drain_ctr = mem_rd_data.flood_counter;
        if (cmd_reg == CMD_TICK) begin
            if (cls_reg == CLS_UNKNOWN) begin
                drain_ctr = (mem_rd_data.flood_counter != '0)
                          ? mem_rd_data.flood_counter - 1'b1 : '0;
            end else if (mem_rd_data.grace_done) begin
                drain_ctr = (mem_rd_data.flood_counter > CTR_W'(drain_reg))
                          ? mem_rd_data.flood_counter - CTR_W'(drain_reg) : '0;
            end else begin
                drain_ctr = '0;
            end
        end
        mul_c   = (mem_rd_data.grace_done ? burst_max_reg : burst_rate_reg) * cost_reg;
        limit_c = bonus_c ? CTR_W'({mul_c, 2'b00}) : CTR_W'(mul_c);
    end

    always_comb begin
        // unknown client: capped at burst_max, 1 token per line
        bm_ext    = CTR_W'(burst_max_reg);
        unk_below = ctr_reg < bm_ext;
        unk_gap   = bm_ext - ctr_reg;
        unk_gap_l = LINES_W'(unk_gap);
        adm_unk   = '0;
        if (unk_below) begin
            adm_unk = (unk_gap_l < queued_reg) ? unk_gap_l : queued_reg;
        end
        unk_sum = {1'b0, ctr_reg} + (CTR_W + 1)'(queued_reg);
        ctr_unk = bm_ext;
        if (unk_below && (unk_sum < (CTR_W + 1)'(bm_ext))) begin
            ctr_unk = CTR_W'(unk_sum);
        end
        // registered client: ceiling and go decision
        ceil_c = (cost_reg == '0) ? '0 : limit_reg + CTR_W'(cost_reg) - 1'b1;
        reg_go = (age_reg >= delay_reg) && (cost_reg != '0) && (ctr_reg < limit_reg);
        ctr_clamp = (ctr_reg > ceil_c) ? ceil_c : ctr_reg;
    end

    assign div_req.start    = (state_reg == S_ADMIT) && (cls_reg == CLS_REGISTERED) && reg_go;
    assign div_req.dividend = limit_reg - ctr_reg + CTR_W'(cost_reg) - 1'b1;
    assign div_req.divisor  = cost_reg;

    assign quot_l  = LINES_W'(div_rsp.quotient);
    assign adm_div = (quot_l < queued_reg) ? quot_l : queued_reg;
    assign add_sum = {1'b0, ctr_reg} + {1'b0, prod_reg};
    assign ctr_add = (add_sum > (CTR_W + 1)'(ceil_reg)) ? ceil_reg : CTR_W'(add_sum);

    // lines still queued after admission decide excess flood on a read
    assign left_lines = queued_reg - adm_reg;
    assign excess_c   = in_range_reg && (cmd_reg == CMD_READ) && (cls_reg != CLS_SERVER)
                     && !bonus_c && (left_lines > maxq_reg);

    assign mem_we                 = (state_reg == S_FINISH) && out_free && in_range_reg;
    assign mem_wr_data.grace_done = grace_reg;
    assign mem_wr_data.flood_counter = ctr_reg;

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if ((state_reg == S_FINISH) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        cmd_reg      <= fcb_cmd_t'(s_tuser);
                        id_reg       <= s_tdata[9:0];
                        cls_reg      <= fcb_class_t'(s_tdata[11:10]);
                        oper_reg     <= s_tdata[12];
                        queued_reg   <= s_tdata[24:13];
                        age_reg      <= s_tdata[40:25];
                        in_range_reg <= 32'(s_tdata[9:0]) < NUM_CLIENTS;
                        state_reg    <= S_READ;
                    end
                end
                S_READ: begin
                    state_reg <= S_DRAIN;
                end
                S_DRAIN: begin
                    adm_reg   <= '0;
                    limit_reg <= limit_c;
                    if (!in_range_reg) begin
                        grace_reg <= mem_rd_data.grace_done;
                        ctr_reg   <= '0;
                        state_reg <= S_FINISH;
                    end else if (cmd_reg == CMD_END_GRACE) begin
                        grace_reg <= 1'b1;
                        ctr_reg   <= '0;
                        state_reg <= S_FINISH;
                    end else if (cmd_reg == CMD_NEW_CLIENT) begin
                        grace_reg <= 1'b0;
                        ctr_reg   <= '0;
                        state_reg <= S_FINISH;
                    end else begin
                        grace_reg <= mem_rd_data.grace_done;
                        ctr_reg   <= drain_ctr;
                        state_reg <= S_ADMIT;
                    end
                end
                S_ADMIT: begin
                    ceil_reg <= ceil_c;
                    case (cls_reg)
                        CLS_UNKNOWN: begin
                            adm_reg   <= adm_unk;
                            ctr_reg   <= ctr_unk;
                            state_reg <= S_FINISH;
                        end
                        CLS_REGISTERED: begin
                            if (reg_go) begin
                                state_reg <= S_DIV;
                            end else begin
                                ctr_reg   <= ctr_clamp;
                                state_reg <= S_FINISH;
                            end
                        end
                        default: begin
                            // server or exempt: no limit
                            adm_reg   <= queued_reg;
                            state_reg <= S_FINISH;
                        end
                    endcase
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        adm_reg   <= adm_div;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    prod_reg  <= CTR_W'(adm_reg) * CTR_W'(cost_reg);
                    state_reg <= S_ADD;
                end
                S_ADD: begin
                    ctr_reg   <= ctr_add;
                    state_reg <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) begin
                        m_tdata_reg  <= {7'b0, ctr_reg[OUT_CTR_W-1:0], excess_c,
                                         adm_reg, id_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- submodules ----------------
    fcb_mem #(
        .DEPTH (NUM_CLIENTS)
    ) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (state_reg == S_READ),
        .rd_addr  (mem_addr),
        .rd_data  (mem_rd_data),
        .wr_en    (mem_we),
        .wr_addr  (mem_addr),
        .wr_data  (mem_wr_data),
        .clr_busy (clr_busy)
    );

    fcb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ---------------- checks ----------------
    logic [CTR_W:0] div_bound;
    assign div_bound = (CTR_W + 1)'({cost_reg, {QUOT_W{1'b0}}});

    `FCB_ASSERT_IMP(a_no_write_in_clear, aclk, aresetn, mem_we, !clr_busy)
    `FCB_ASSERT_IMP(a_div_done_in_div, aclk, aresetn, div_rsp.done, state_reg == S_DIV)
    `FCB_ASSERT_IMP(a_div_quot_fits, aclk, aresetn, div_req.start, {1'b0, div_req.dividend} < div_bound)
    `FCB_ASSERT_NXT(a_div_runs, aclk, aresetn, div_req.start, div_rsp.busy && (state_reg == S_DIV))
    `FCB_ASSERT_IMP(a_adm_le_queued, aclk, aresetn, state_reg == S_FINISH, adm_reg <= queued_reg)
    `FCB_ASSERT_IMP(a_unknown_cap, aclk, aresetn, (state_reg == S_FINISH) && (cls_reg == CLS_UNKNOWN) && ((cmd_reg == CMD_TICK) || (cmd_reg == CMD_READ)), ctr_reg <= CTR_W'(burst_max_reg))

endmodule
`default_nettype wire
